>>> sv/fbc32_pkg.sv
// ----------------------------------------------------------------------------
// fbc32_pkg
// Shared types, constants and round functions of the 32-bit Feistel cipher.
// ----------------------------------------------------------------------------
package fbc32_pkg;

  localparam int MAX_ROUNDS = 4;
  localparam int RND_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIPHER_KEY   = 2'd0,
    REG_ROUND_COUNT  = 2'd1,
    REG_DECRYPT_MODE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] block_in;
    logic        last_in;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] block_out;
    logic        last_out;
  } out_beat_t;

  // Successor of each nibble in the substitution cycle.
  localparam logic [3:0] SBOX_NEXT [16] = '{
    4'd7, 4'd2, 4'd15, 4'd10, 4'd13, 4'd9, 4'd12, 4'd14,
    4'd3, 4'd0, 4'd6,  4'd8,  4'd5,  4'd1, 4'd4,  4'd11
  };

  function automatic logic [15:0] bit_perm(input logic [15:0] s);
    logic [15:0] p;
    logic [3:0]  src;
    logic [3:0]  dst;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      src = 4'(15 - ((13 * i + 1) % 16));
      dst = 4'(15 - ((13 * (i + 1) + 1) % 16));
      p[dst] = s[src];
    end
    return p;
  endfunction

  function automatic logic [15:0] round_fn(input logic [15:0] x, input logic [15:0] k);
    logic [15:0] y;
    logic [15:0] s;
    y = x ^ k;
    for (int n = 0; n < 4; n++) begin
      s[4*n +: 4] = SBOX_NEXT[y[4*n +: 4]];
    end
    return bit_perm(s);
  endfunction

  function automatic logic [31:0] enc_round(input logic [31:0] b, input logic [15:0] k,
                                            input logic [31:0] w);
    return {b[15:0] ^ round_fn(b[31:16], k), b[31:16]} ^ w;
  endfunction

  function automatic logic [31:0] dec_round(input logic [31:0] b, input logic [15:0] k,
                                            input logic [31:0] w);
    logic [31:0] t;
    t = b ^ w;
    return {t[15:0], t[31:16] ^ round_fn(t[15:0], k)};
  endfunction

endpackage

>>> sv/feistel_block_cipher_32_top.sv
// ----------------------------------------------------------------------------
// feistel_block_cipher_32_top
// Pipelined 32-bit Feistel cipher with key whitening, one round per stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken on start when busy is low; busy never rises, so a
//   block may be presented in every cycle.
//   Each block passes through MAX_ROUNDS register stages, one Feistel round
//   per stage; a stage beyond the configured round count passes the block on.
//   The result leaves the last of these stages with out_valid high for
//   exactly one cycle, and results leave in input order.
//   Throughput is one block per cycle, set by the round pipeline.
//   The receiver cannot stall the output and must take every beat.
//   The user must write configuration through cfg_we, cfg_idx and cfg_wdata
//   only while no block is in flight (unenforced); unknown indexes are ignored.
//   Synchronous reset clears the pipeline valid bits and sets the key to
//   zero, the round count to four and the mode to encrypt.
// ----------------------------------------------------------------------------
module feistel_block_cipher_32_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  fbc32_pkg::in_beat_t                  in_data,
  output logic                                 out_valid,
  output fbc32_pkg::out_beat_t                 out_data,
  input  logic                                 cfg_we,
  input  logic [fbc32_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [fbc32_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fbc32_pkg::*;

  logic [31:0]      key_r;
  logic [RND_W-1:0] rounds_r;
  logic             decrypt_r;

  logic [RND_W-1:0] n_eff;
  logic [15:0]      k0;
  logic [15:0]      k1;
  logic [31:0]      white;

  logic             vld_r  [MAX_ROUNDS];
  logic [31:0]      blk_r  [MAX_ROUNDS];
  logic             last_r [MAX_ROUNDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      rounds_r  <= RND_W'(MAX_ROUNDS);
      decrypt_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_CIPHER_KEY:   key_r     <= cfg_wdata[31:0];
        REG_ROUND_COUNT:  rounds_r  <= cfg_wdata[RND_W-1:0];
        REG_DECRYPT_MODE: decrypt_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign n_eff = (rounds_r > RND_W'(MAX_ROUNDS)) ? RND_W'(MAX_ROUNDS) : rounds_r;
  assign k0    = key_r[15:0];
  assign k1    = key_r[31:16];
  assign white = {k0 ^ k1, k0 ^ k1};
  assign busy  = 1'b0;

  for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_stage
    localparam logic [RND_W-1:0] STG = RND_W'(g);
    logic        vld_in;
    logic [31:0] blk_in;
    logic        last_in;
    logic        use_k1;
    logic [15:0] rkey;
    logic [31:0] blk_nxt;

    if (g == 0) begin : g_first
      assign vld_in  = start & ~busy;
      assign blk_in  = in_data.block_in;
      assign last_in = in_data.last_in;
    end else begin : g_rest
      assign vld_in  = vld_r[g-1];
      assign blk_in  = blk_r[g-1];
      assign last_in = last_r[g-1];
    end

    // In decrypt mode this stage runs round n-1-g, whose parity picks the key half.
    assign use_k1 = decrypt_r ? ~(n_eff[0] ^ STG[0]) : STG[0];
    assign rkey   = use_k1 ? k1 : k0;

    always_comb begin
      if (STG >= n_eff) begin
        blk_nxt = blk_in;
      end else if (decrypt_r) begin
        blk_nxt = dec_round(blk_in, rkey, white);
      end else begin
        blk_nxt = enc_round(blk_in, rkey, white);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      blk_r[g]  <= blk_nxt;
      last_r[g] <= last_in;
    end
  end

  assign out_valid          = vld_r[MAX_ROUNDS-1];
  assign out_data.block_out = blk_r[MAX_ROUNDS-1];
  assign out_data.last_out  = last_r[MAX_ROUNDS-1];

endmodule

>>> sv/fbc32_checker.sv
// ----------------------------------------------------------------------------
// fbc32_checker
// Port-level timing checks of the cipher pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module fbc32_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  fbc32_pkg::in_beat_t                  in_data,
  input  logic                                 out_valid,
  input  fbc32_pkg::out_beat_t                 out_data,
  input  logic                                 cfg_we,
  input  logic [fbc32_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [fbc32_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fbc32_pkg::*;

  logic cfg_seen;
  assign cfg_seen = cfg_we & (|cfg_idx | |cfg_wdata | 1'b1);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised although the pipeline always accepts");

  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, MAX_ROUNDS))
    else $error("result beat without an accepted input beat");

  a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && $past(rst_n)) |-> ##MAX_ROUNDS (out_valid || !$past(rst_n, 1)))
    else $error("accepted input beat produced no result");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_out == $past(in_data.last_in, MAX_ROUNDS)))
    else $error("last flag does not match its input beat");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_seen && out_valid) |-> $past(start && !busy, MAX_ROUNDS))
    else $error("result beat during a configuration write has no source");

endmodule

bind feistel_block_cipher_32_top fbc32_checker u_fbc32_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx),
  .cfg_wdata (cfg_wdata)
);
